[sv/cabs_pkg.sv]
// Shared widths, limits, register indexes and unit request/response types
// for the CSI amplitude batch statistics block. No dependencies.
package cabs_pkg;

   localparam int MAX_PAIRS = 512;
   localparam int MAX_BATCH = 1024;
   localparam int BATCH_RESET = 100;

   localparam int MAC_W = 48;
   localparam int SMP_W = 8;
   localparam int CHAN_W = 4;
   localparam int BLEN_W = 11;
   localparam int PC_W = $clog2(MAX_PAIRS + 1);
   localparam int PKC_W = $clog2(MAX_BATCH + 1);
   localparam int PSUM_W = 25;
   localparam int BSUM_W = 26;
   localparam int BSQ_W = 42;
   localparam int SQ_SPLIT = BSQ_W / 2;
   localparam int AMP_W = 16;
   localparam int SEQ_W = 32;

   localparam int MUL_W = 26;
   localparam int PROD_W = 2 * MUL_W;

   localparam int DIV_NW = 53;
   localparam int DIV_DW = 21;
   localparam int DIV_CW = $clog2(DIV_NW);

   localparam int SQ_W = 32;
   localparam int SQ_RW = SQ_W / 2;
   localparam int SQ_CW = $clog2(SQ_RW);

   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = MAC_W;
   localparam logic [CSR_IDX_W-1:0] CSR_AP_MAC = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_LEN = CSR_IDX_W'(1);

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic             done;
      logic [SQ_RW-1:0] root;
   } sqrt_rsp_type;

endpackage

[sv/cabs_div.sv]
// Restoring divider, one quotient bit per cycle, DIV_NW steps per division.
// Depends on cabs_pkg for widths and the request/response types.
module cabs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cabs_pkg::div_req_type req,
   output cabs_pkg::div_rsp_type rsp
);
   import cabs_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] num_ff, num_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW:0]   rem_sh;
   logic [DIV_DW:0]   rem_diff;
   logic              qbit;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      rem_sh   = {rem_ff, num_ff[DIV_NW-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      qbit     = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = req.dividend;
         den_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            qbit   = 1'b1;
            rem_in = rem_diff[DIV_DW-1:0];
         end else begin
            rem_in = rem_sh[DIV_DW-1:0];
         end
         num_in = {num_ff[DIV_NW-2:0], qbit};
         cnt_in = cnt_ff + DIV_CW'(1);
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

endmodule

[sv/cabs_sqrt.sv]
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// Depends on cabs_pkg for widths and the request/response types.
module cabs_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  cabs_pkg::sqrt_req_type req,
   output cabs_pkg::sqrt_rsp_type rsp
);
   import cabs_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SQ_CW-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]  val_ff, val_in;
   logic [SQ_RW:0]   rem_ff, rem_in;
   logic [SQ_RW-1:0] root_ff, root_in;
   logic [SQ_RW-1:0] res_ff, res_in;
   logic [SQ_RW+1:0] rem_sh;
   logic [SQ_RW+1:0] trial;
   logic [SQ_RW+1:0] rem_diff;
   logic [SQ_RW:0]   rounded;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      res_in   = res_ff;
      rem_sh   = {rem_ff[SQ_RW-1:0], val_ff[SQ_W-1 -: 2]};
      trial    = {root_ff, 2'b01};
      rem_diff = rem_sh - trial;
      rounded  = '0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = rem_diff[SQ_RW:0];
            root_in = {root_ff[SQ_RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[SQ_RW:0];
            root_in = {root_ff[SQ_RW-2:0], 1'b0};
         end
         val_in = {val_ff[SQ_W-3:0], 2'b00};
         cnt_in = cnt_ff + SQ_CW'(1);
         if (cnt_ff == SQ_CW'(SQ_RW - 1)) begin
            rounded = {1'b0, root_in} + (SQ_RW + 1)'(rem_in > {1'b0, root_in});
            res_in  = rounded[SQ_RW-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      res_ff  <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = res_ff;

endmodule

[sv/csi_amplitude_batch_stats.sv]
// Top level of the CSI amplitude batch statistics block: sequencer, shared
// multiplier, batch state and result register. Uses cabs_pkg, cabs_div, cabs_sqrt.
//
// The req_ channel carries one I/Q pair per item, tlast marking the last pair
// of a packet. Items whose source MAC differs from ap_mac are dropped. A kept
// pair takes two multiplier passes and a 16-step square root. The last pair
// of a packet adds the 53-step divider and the mean square. The packet that
// closes a batch adds four multiplier passes, two 53-step divisions and one
// 16-step root. The divider and the root unit are shared between these steps.
// req_tready is high only while the sequencer waits for an item.
// The rsp_ channel carries one item per finished batch from an output
// register; new input items are taken while it waits. If a second batch
// finishes before rsp_tready takes the first, the sequencer holds until
// the register frees up. The csr_ channel is always ready.
// Reset clears all sums, counters and the sequence number, sets ap_mac to
// zero and batch_length to 100, and empties the output register.
module csi_amplitude_batch_stats (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // i_sample, q_sample, src_mac, rssi_in, channel_in, noise_in, zero pad
   input  logic [cabs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // seq, rssi_out, channel_out, noise_out, avg_amplitude, amp_std, zero pad
   output logic [cabs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cabs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cabs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import cabs_pkg::*;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_MAG_I    = 5'd1;
   localparam logic [4:0] ST_MAG_Q    = 5'd2;
   localparam logic [4:0] ST_MAG_SUM  = 5'd3;
   localparam logic [4:0] ST_MAG_WAIT = 5'd4;
   localparam logic [4:0] ST_PKT_DIV  = 5'd5;
   localparam logic [4:0] ST_PKT_WAIT = 5'd6;
   localparam logic [4:0] ST_PKT_SQ   = 5'd7;
   localparam logic [4:0] ST_PKT_ACC  = 5'd8;
   localparam logic [4:0] ST_B_SS     = 5'd9;
   localparam logic [4:0] ST_B_NL     = 5'd10;
   localparam logic [4:0] ST_B_NH     = 5'd11;
   localparam logic [4:0] ST_B_NN     = 5'd12;
   localparam logic [4:0] ST_B_VDIV   = 5'd13;
   localparam logic [4:0] ST_B_VWAIT  = 5'd14;
   localparam logic [4:0] ST_B_ROOT   = 5'd15;
   localparam logic [4:0] ST_B_RWAIT  = 5'd16;
   localparam logic [4:0] ST_B_MDIV   = 5'd17;
   localparam logic [4:0] ST_B_MWAIT  = 5'd18;
   localparam logic [4:0] ST_B_OUT    = 5'd19;

   logic [4:0]         state_ff, state_in;
   logic [MAC_W-1:0]   ap_mac_ff, ap_mac_in;
   logic [BLEN_W-1:0]  blen_ff, blen_in;
   logic [PC_W-1:0]    pair_count_ff, pair_count_in;
   logic [PSUM_W-1:0]  psum_ff, psum_in;
   logic [PKC_W-1:0]   pkt_count_ff, pkt_count_in;
   logic [BSUM_W-1:0]  bsum_ff, bsum_in;
   logic [BSQ_W-1:0]   bsq_ff, bsq_in;
   logic [SMP_W-1:0]   held_rssi_ff, held_rssi_in;
   logic [CHAN_W-1:0]  held_chan_ff, held_chan_in;
   logic [SMP_W-1:0]   held_noise_ff, held_noise_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [SMP_W-1:0]   i_ff, i_in;
   logic [SMP_W-1:0]   q_ff, q_in;
   logic               last_ff, last_in;
   logic [SMP_W-1:0]   rssi_ff, rssi_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [SMP_W-1:0]   noise_ff, noise_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIV_NW-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  ss_ff, ss_in;
   logic [AMP_W-1:0]   pmean_ff, pmean_in;
   logic [SQ_W-1:0]    var_ff, var_in;
   logic [AMP_W-1:0]   std_ff, std_in;
   logic [AMP_W-1:0]   mean_ff, mean_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic               take;
   logic               mac_ok;
   logic [SMP_W-1:0]   i_abs, q_abs;
   logic [PKC_W-1:0]   lim;
   logic [PKC_W-1:0]   pkt_next;
   logic [SMP_W+SMP_W:0] mag_sq;
   logic [DIV_NW-1:0]  diff;
   logic               rsp_load;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   sqrt_req_type       sqrt_req;
   sqrt_rsp_type       sqrt_rsp;

   cabs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cabs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign take       = req_tvalid && req_tready;
   assign mac_ok     = (req_tdata[63:16] == ap_mac_ff);
   assign i_abs      = req_tdata[7] ? SMP_W'(~req_tdata[7:0] + 8'd1) : req_tdata[7:0];
   assign q_abs      = req_tdata[15] ? SMP_W'(~req_tdata[15:8] + 8'd1) : req_tdata[15:8];
   assign mag_sq     = {1'b0, acc_ff[15:0]} + {1'b0, prod_ff[15:0]};
   assign diff       = (acc_ff > {1'b0, ss_ff}) ? acc_ff - {1'b0, ss_ff} : '0;
   assign pkt_next   = pkt_count_ff + PKC_W'(1);

   always_comb begin
      if (blen_ff == '0) begin
         lim = PKC_W'(1);
      end else if (blen_ff > BLEN_W'(MAX_BATCH)) begin
         lim = PKC_W'(MAX_BATCH);
      end else begin
         lim = PKC_W'(blen_ff);
      end
   end

   always_comb begin
      case (state_ff)
         ST_MAG_I: begin
            mul_a = MUL_W'(i_ff);
            mul_b = MUL_W'(i_ff);
         end
         ST_MAG_Q: begin
            mul_a = MUL_W'(q_ff);
            mul_b = MUL_W'(q_ff);
         end
         ST_PKT_SQ: begin
            mul_a = MUL_W'(pmean_ff);
            mul_b = MUL_W'(pmean_ff);
         end
         ST_B_SS: begin
            mul_a = MUL_W'(bsum_ff);
            mul_b = MUL_W'(bsum_ff);
         end
         ST_B_NL: begin
            mul_a = MUL_W'(pkt_count_ff);
            mul_b = MUL_W'(bsq_ff[SQ_SPLIT-1:0]);
         end
         ST_B_NH: begin
            mul_a = MUL_W'(pkt_count_ff);
            mul_b = MUL_W'(bsq_ff[BSQ_W-1:SQ_SPLIT]);
         end
         ST_B_NN: begin
            mul_a = MUL_W'(pkt_count_ff);
            mul_b = MUL_W'(pkt_count_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      ap_mac_in     = ap_mac_ff;
      blen_in       = blen_ff;
      pair_count_in = pair_count_ff;
      psum_in       = psum_ff;
      pkt_count_in  = pkt_count_ff;
      bsum_in       = bsum_ff;
      bsq_in        = bsq_ff;
      held_rssi_in  = held_rssi_ff;
      held_chan_in  = held_chan_ff;
      held_noise_in = held_noise_ff;
      seq_in        = seq_ff;
      i_in          = i_ff;
      q_in          = q_ff;
      last_in       = last_ff;
      rssi_in       = rssi_ff;
      chan_in       = chan_ff;
      noise_in      = noise_ff;
      acc_in        = acc_ff;
      ss_in         = ss_ff;
      pmean_in      = pmean_ff;
      var_in        = var_ff;
      std_in        = std_ff;
      mean_in       = mean_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_load      = 1'b0;
      div_req       = '0;
      sqrt_req      = '0;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_AP_MAC) begin
            ap_mac_in = csr_data[MAC_W-1:0];
         end else if (csr_index == CSR_BATCH_LEN) begin
            blen_in = csr_data[BLEN_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (take && mac_ok) begin
               i_in     = i_abs;
               q_in     = q_abs;
               last_in  = req_tlast;
               rssi_in  = req_tdata[71:64];
               chan_in  = req_tdata[75:72];
               noise_in = req_tdata[83:76];
               if (pair_count_ff < PC_W'(MAX_PAIRS)) begin
                  state_in = ST_MAG_I;
               end else if (req_tlast) begin
                  state_in = ST_PKT_DIV;
               end
            end
         end
         ST_MAG_I: begin
            state_in = ST_MAG_Q;
         end
         ST_MAG_Q: begin
            acc_in   = DIV_NW'(prod_ff);
            state_in = ST_MAG_SUM;
         end
         ST_MAG_SUM: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = {mag_sq[15:0], 16'h0000};
            state_in          = ST_MAG_WAIT;
         end
         ST_MAG_WAIT: begin
            if (sqrt_rsp.done) begin
               psum_in       = psum_ff + PSUM_W'(sqrt_rsp.root);
               pair_count_in = pair_count_ff + PC_W'(1);
               state_in      = last_ff ? ST_PKT_DIV : ST_IDLE;
            end
         end
         ST_PKT_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NW'(psum_ff) + DIV_NW'(pair_count_ff >> 1);
            div_req.divisor  = DIV_DW'(pair_count_ff);
            state_in         = ST_PKT_WAIT;
         end
         ST_PKT_WAIT: begin
            if (div_rsp.done) begin
               pmean_in      = div_rsp.quotient[AMP_W-1:0];
               pair_count_in = '0;
               psum_in       = '0;
               state_in      = ST_PKT_SQ;
            end
         end
         ST_PKT_SQ: begin
            state_in = ST_PKT_ACC;
         end
         ST_PKT_ACC: begin
            if (pkt_count_ff == '0) begin
               held_rssi_in  = rssi_ff;
               held_chan_in  = chan_ff;
               held_noise_in = noise_ff;
            end
            bsum_in      = bsum_ff + BSUM_W'(pmean_ff);
            bsq_in       = bsq_ff + BSQ_W'(prod_ff[2*AMP_W-1:0]);
            pkt_count_in = pkt_next;
            state_in     = (pkt_next >= lim) ? ST_B_SS : ST_IDLE;
         end
         ST_B_SS: begin
            state_in = ST_B_NL;
         end
         ST_B_NL: begin
            ss_in    = prod_ff;
            state_in = ST_B_NH;
         end
         ST_B_NH: begin
            acc_in   = DIV_NW'(prod_ff);
            state_in = ST_B_NN;
         end
         ST_B_NN: begin
            acc_in   = acc_ff + {prod_ff[DIV_NW-SQ_SPLIT-1:0], SQ_SPLIT'(0)};
            state_in = ST_B_VDIV;
         end
         ST_B_VDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = diff;
            div_req.divisor  = prod_ff[DIV_DW-1:0];
            state_in         = ST_B_VWAIT;
         end
         ST_B_VWAIT: begin
            if (div_rsp.done) begin
               var_in   = div_rsp.quotient[SQ_W-1:0];
               state_in = ST_B_ROOT;
            end
         end
         ST_B_ROOT: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = var_ff;
            state_in          = ST_B_RWAIT;
         end
         ST_B_RWAIT: begin
            if (sqrt_rsp.done) begin
               std_in   = sqrt_rsp.root;
               state_in = ST_B_MDIV;
            end
         end
         ST_B_MDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NW'(bsum_ff) + DIV_NW'(pkt_count_ff >> 1);
            div_req.divisor  = DIV_DW'(pkt_count_ff);
            state_in         = ST_B_MWAIT;
         end
         ST_B_MWAIT: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[AMP_W-1:0];
               state_in = ST_B_OUT;
            end
         end
         ST_B_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_data_in  = {4'h0, std_ff, mean_ff, held_noise_ff, held_chan_ff,
                               held_rssi_ff, seq_ff};
               seq_in       = seq_ff + SEQ_W'(1);
               pkt_count_in = '0;
               bsum_in      = '0;
               bsq_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ap_mac_ff     <= '0;
         blen_ff       <= BLEN_W'(BATCH_RESET);
         pair_count_ff <= '0;
         psum_ff       <= '0;
         pkt_count_ff  <= '0;
         bsum_ff       <= '0;
         bsq_ff        <= '0;
         held_rssi_ff  <= '0;
         held_chan_ff  <= '0;
         held_noise_ff <= '0;
         seq_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ap_mac_ff     <= ap_mac_in;
         blen_ff       <= blen_in;
         pair_count_ff <= pair_count_in;
         psum_ff       <= psum_in;
         pkt_count_ff  <= pkt_count_in;
         bsum_ff       <= bsum_in;
         bsq_ff        <= bsq_in;
         held_rssi_ff  <= held_rssi_in;
         held_chan_ff  <= held_chan_in;
         held_noise_ff <= held_noise_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      q_ff        <= q_in;
      last_ff     <= last_in;
      rssi_ff     <= rssi_in;
      chan_ff     <= chan_in;
      noise_ff    <= noise_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      ss_ff       <= ss_in;
      pmean_ff    <= pmean_in;
      var_ff      <= var_in;
      std_ff      <= std_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_pair_bound: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= PC_W'(MAX_PAIRS))
      else $error("pair count beyond limit");

   a_idle_batch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pkt_count_ff < PKC_W'(MAX_BATCH)))
      else $error("full batch left unreported");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_PKT_WAIT || state_ff == ST_B_VWAIT ||
                        state_ff == ST_B_MWAIT))
      else $error("divider result arrived outside a wait state");

   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      sqrt_rsp.done |-> (state_ff == ST_MAG_WAIT || state_ff == ST_B_RWAIT))
      else $error("root result arrived outside a wait state");
`endif

endmodule
